FILE: rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and controller/datapath interface types for the
// midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int AXIS_BITS   = 9;
    localparam int COORD_BITS  = 11;
    localparam int CENTRE_BITS = COORD_BITS - 1;
    localparam int STEP_BITS   = AXIS_BITS + 1;
    localparam int SQ_BITS     = 2 * AXIS_BITS;
    localparam int MUL_BITS    = 2 * AXIS_BITS + 2;
    localparam int PROD_BITS   = 2 * MUL_BITS;
    localparam int TERM_BITS   = 3 * AXIS_BITS + 3;
    localparam int DEC_BITS    = 4 * AXIS_BITS + 6;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_MUL_AB,
        ST_INIT,
        ST_STEP,
        ST_R2_XX,
        ST_R2_B2P,
        ST_R2_YY,
        ST_R2_A2P,
        ST_R2_AB,
        ST_R2_FIX,
        ST_R2_STEP,
        ST_EMIT,
        ST_BLANK
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_A2B,
        MUL_XX,
        MUL_YY,
        MUL_B2P,
        MUL_A2P,
        MUL_A2B2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_SAVE_A2,
        ACC_SAVE_B2,
        ACC_INIT,
        ACC_STEP1,
        ACC_STEP2,
        ACC_R2_LOAD,
        ACC_R2_ADD,
        ACC_R2_SUB
    } acc_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     out_load;
        logic     out_blank;
    } cmd_t;

    typedef struct packed {
        logic region_two;
        logic below;
        logic finished;
    } status_t;

endpackage

FILE: rtl/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for start, step and region change; owns the handshakes and
// the result valid flag.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    output logic             m_valid,
    input  logic             m_ready,
    input  mer_pkg::status_t status,
    output mer_pkg::cmd_t    cmd
);

    mer_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;
    logic            accept;

    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mer_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_sel   = mer_pkg::MUL_NONE;
        cmd.acc_op    = mer_pkg::ACC_NONE;
        cmd.out_load  = 1'b0;
        cmd.out_blank = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            mer_pkg::ST_SQ_A: begin
                cmd.mul_sel = mer_pkg::MUL_AA;
                state_next  = mer_pkg::ST_SQ_B;
            end
            mer_pkg::ST_SQ_B: begin
                cmd.acc_op  = mer_pkg::ACC_SAVE_A2;
                cmd.mul_sel = mer_pkg::MUL_BB;
                state_next  = mer_pkg::ST_MUL_AB;
            end
            mer_pkg::ST_MUL_AB: begin
                cmd.acc_op  = mer_pkg::ACC_SAVE_B2;
                cmd.mul_sel = mer_pkg::MUL_A2B;
                state_next  = mer_pkg::ST_INIT;
            end
            mer_pkg::ST_INIT: begin
                cmd.acc_op = mer_pkg::ACC_INIT;
                state_next = mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_STEP: begin
                priority if (status.region_two) begin
                    cmd.acc_op = mer_pkg::ACC_STEP2;
                    state_next = mer_pkg::ST_EMIT;
                end else if (status.below) begin
                    cmd.acc_op = mer_pkg::ACC_STEP1;
                    state_next = mer_pkg::ST_EMIT;
                end else begin
                    state_next = mer_pkg::ST_R2_XX;
                end
            end
            mer_pkg::ST_R2_XX: begin
                cmd.mul_sel = mer_pkg::MUL_XX;
                state_next  = mer_pkg::ST_R2_B2P;
            end
            mer_pkg::ST_R2_B2P: begin
                cmd.mul_sel = mer_pkg::MUL_B2P;
                state_next  = mer_pkg::ST_R2_YY;
            end
            mer_pkg::ST_R2_YY: begin
                cmd.acc_op  = mer_pkg::ACC_R2_LOAD;
                cmd.mul_sel = mer_pkg::MUL_YY;
                state_next  = mer_pkg::ST_R2_A2P;
            end
            mer_pkg::ST_R2_A2P: begin
                cmd.mul_sel = mer_pkg::MUL_A2P;
                state_next  = mer_pkg::ST_R2_AB;
            end
            mer_pkg::ST_R2_AB: begin
                cmd.acc_op  = mer_pkg::ACC_R2_ADD;
                cmd.mul_sel = mer_pkg::MUL_A2B2;
                state_next  = mer_pkg::ST_R2_FIX;
            end
            mer_pkg::ST_R2_FIX: begin
                cmd.acc_op = mer_pkg::ACC_R2_SUB;
                state_next = mer_pkg::ST_R2_STEP;
            end
            mer_pkg::ST_R2_STEP: begin
                cmd.acc_op = mer_pkg::ACC_STEP2;
                state_next = mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_EMIT, mer_pkg::ST_BLANK: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_blank = (state_reg == mer_pkg::ST_BLANK);
                    m_valid_next  = 1'b1;
                    s_ready       = 1'b1;
                    state_next    = mer_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase

        // next transaction may enter in idle or while the result is loaded
        if (accept) begin
            cmd.load = (s_operation == mer_pkg::OP_START);
            priority if (s_operation == mer_pkg::OP_START) begin
                state_next = mer_pkg::ST_SQ_A;
            end else if (status.finished) begin
                state_next = mer_pkg::ST_BLANK;
            end else begin
                state_next = mer_pkg::ST_STEP;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_advance_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == mer_pkg::OP_ADVANCE && !status.finished)
        |=> state_reg == mer_pkg::ST_STEP)
        else $error("advance did not start a step");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
        ($past(state_reg) == mer_pkg::ST_EMIT || $past(state_reg) == mer_pkg::ST_BLANK))
        else $error("result valid without emit");
`endif

endmodule

FILE: rtl/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath
// Held ellipse parameters, step position, decision variable, shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  mer_pkg::cmd_t                           cmd,
    output mer_pkg::status_t                        status,
    input  logic        [mer_pkg::AXIS_BITS-1:0]    s_semi_axis_x,
    input  logic        [mer_pkg::AXIS_BITS-1:0]    s_semi_axis_y,
    input  logic signed [mer_pkg::CENTRE_BITS-1:0]  s_center_x,
    input  logic signed [mer_pkg::CENTRE_BITS-1:0]  s_center_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad0_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad0_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad1_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad1_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad2_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad2_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad3_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad3_y,
    output logic                                    m_point_valid,
    output logic                                    m_last_step
);

    logic        [mer_pkg::AXIS_BITS-1:0]   axis_x_reg, axis_y_reg;
    logic signed [mer_pkg::CENTRE_BITS-1:0] cx_reg, cy_reg;
    logic        [mer_pkg::STEP_BITS-1:0]   x_reg, x_next, y_reg, y_next;
    logic        [mer_pkg::SQ_BITS-1:0]     a2_reg, a2_next, b2_reg, b2_next;
    logic signed [mer_pkg::TERM_BITS-1:0]   t_reg, t_next, u_reg, u_next;
    logic signed [mer_pkg::DEC_BITS-1:0]    dec_reg, dec_next;
    logic        [mer_pkg::PROD_BITS-1:0]   prod_reg;
    logic                                   region_two_reg, region_two_next;

    logic        [mer_pkg::MUL_BITS-1:0]    mul_a, mul_b;
    logic        [mer_pkg::PROD_BITS-1:0]   mul_res;
    logic signed [mer_pkg::DEC_BITS-1:0]    a2_w, b2_w, t_w, u_w, p_w;
    logic signed [mer_pkg::COORD_BITS-1:0]  cx_w, cy_w, x_w, y_w;

    assign a2_w = signed'(mer_pkg::DEC_BITS'(a2_reg));
    assign b2_w = signed'(mer_pkg::DEC_BITS'(b2_reg));
    assign t_w  = mer_pkg::DEC_BITS'(t_reg);
    assign u_w  = mer_pkg::DEC_BITS'(u_reg);
    assign p_w  = signed'(mer_pkg::DEC_BITS'(prod_reg));

    assign status.region_two = region_two_reg;
    assign status.below      = (t_reg < u_reg);
    assign status.finished   = (y_reg == '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            mer_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            mer_pkg::MUL_AA: begin
                mul_a = mer_pkg::MUL_BITS'(axis_x_reg);
                mul_b = mer_pkg::MUL_BITS'(axis_x_reg);
            end
            mer_pkg::MUL_BB: begin
                mul_a = mer_pkg::MUL_BITS'(axis_y_reg);
                mul_b = mer_pkg::MUL_BITS'(axis_y_reg);
            end
            mer_pkg::MUL_A2B: begin
                mul_a = mer_pkg::MUL_BITS'(a2_reg);
                mul_b = mer_pkg::MUL_BITS'(axis_y_reg);
            end
            mer_pkg::MUL_XX: begin
                mul_a = mer_pkg::MUL_BITS'(x_reg);
                mul_b = mer_pkg::MUL_BITS'(x_reg) + mer_pkg::MUL_BITS'(1'b1);
            end
            mer_pkg::MUL_YY: begin
                mul_a = mer_pkg::MUL_BITS'(y_reg - mer_pkg::STEP_BITS'(1'b1));
                mul_b = mer_pkg::MUL_BITS'(y_reg - mer_pkg::STEP_BITS'(1'b1));
            end
            mer_pkg::MUL_B2P: begin
                mul_a = mer_pkg::MUL_BITS'(b2_reg);
                mul_b = prod_reg[mer_pkg::MUL_BITS-1:0];
            end
            mer_pkg::MUL_A2P: begin
                mul_a = mer_pkg::MUL_BITS'(a2_reg);
                mul_b = prod_reg[mer_pkg::MUL_BITS-1:0];
            end
            mer_pkg::MUL_A2B2: begin
                mul_a = mer_pkg::MUL_BITS'(a2_reg);
                mul_b = mer_pkg::MUL_BITS'(b2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mer_pkg::PROD_BITS'(mul_a) * mer_pkg::PROD_BITS'(mul_b);

    // decision, increments and position update
    always_comb begin
        x_next          = x_reg;
        y_next          = y_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        t_next          = t_reg;
        u_next          = u_reg;
        dec_next        = dec_reg;
        region_two_next = region_two_reg;
        unique case (cmd.acc_op)
            mer_pkg::ACC_NONE: begin
                dec_next = dec_reg;
            end
            mer_pkg::ACC_SAVE_A2: begin
                a2_next = prod_reg[mer_pkg::SQ_BITS-1:0];
            end
            mer_pkg::ACC_SAVE_B2: begin
                b2_next = prod_reg[mer_pkg::SQ_BITS-1:0];
            end
            mer_pkg::ACC_INIT: begin
                t_next   = mer_pkg::TERM_BITS'(b2_w <<< 1);
                u_next   = mer_pkg::TERM_BITS'((p_w <<< 1) - a2_w);
                dec_next = (b2_w <<< 2) - (p_w <<< 2) + a2_w;
            end
            mer_pkg::ACC_STEP1: begin
                if (dec_reg < 0) begin
                    dec_next = dec_reg + (t_w <<< 2) + (b2_w <<< 2);
                end else begin
                    dec_next = dec_reg + (t_w <<< 2) + (b2_w <<< 2)
                             + (a2_w <<< 2) - (u_w <<< 2);
                    y_next   = y_reg - mer_pkg::STEP_BITS'(1'b1);
                    u_next   = u_reg - mer_pkg::TERM_BITS'(a2_w <<< 1);
                end
                x_next = x_reg + mer_pkg::STEP_BITS'(1'b1);
                t_next = t_reg + mer_pkg::TERM_BITS'(b2_w <<< 1);
            end
            mer_pkg::ACC_STEP2: begin
                if (dec_reg < 0) begin
                    dec_next = dec_reg + (t_w <<< 2) + (a2_w <<< 3) - (u_w <<< 2);
                    x_next   = x_reg + mer_pkg::STEP_BITS'(1'b1);
                    t_next   = t_reg + mer_pkg::TERM_BITS'(b2_w <<< 1);
                end else begin
                    dec_next = dec_reg + (a2_w <<< 3) - (u_w <<< 2);
                end
                y_next = y_reg - mer_pkg::STEP_BITS'(1'b1);
                u_next = u_reg - mer_pkg::TERM_BITS'(a2_w <<< 1);
            end
            mer_pkg::ACC_R2_LOAD: begin
                dec_next = (p_w <<< 2) + b2_w;
            end
            mer_pkg::ACC_R2_ADD: begin
                dec_next = dec_reg + (p_w <<< 2);
            end
            mer_pkg::ACC_R2_SUB: begin
                dec_next        = dec_reg - (p_w <<< 2);
                region_two_next = 1'b1;
            end
            default: begin
                dec_next = dec_reg;
            end
        endcase
        if (cmd.load) begin
            x_next          = '0;
            y_next          = mer_pkg::STEP_BITS'(s_semi_axis_y);
            region_two_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg          <= '0;
            y_reg          <= '0;
            region_two_reg <= 1'b0;
        end else begin
            x_reg          <= x_next;
            y_reg          <= y_next;
            region_two_reg <= region_two_next;
        end
    end

    always_ff @(posedge aclk) begin
        a2_reg  <= a2_next;
        b2_reg  <= b2_next;
        t_reg   <= t_next;
        u_reg   <= u_next;
        dec_reg <= dec_next;
        if (cmd.mul_sel != mer_pkg::MUL_NONE) begin
            prod_reg <= mul_res;
        end
        if (cmd.load) begin
            axis_x_reg <= s_semi_axis_x;
            axis_y_reg <= s_semi_axis_y;
            cx_reg     <= s_center_x;
            cy_reg     <= s_center_y;
        end
    end

    // result register
    assign cx_w = mer_pkg::COORD_BITS'(cx_reg);
    assign cy_w = mer_pkg::COORD_BITS'(cy_reg);
    assign x_w  = signed'(mer_pkg::COORD_BITS'(x_reg));
    assign y_w  = signed'(mer_pkg::COORD_BITS'(y_reg));

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_blank) begin
                m_quad0_x     <= '0;
                m_quad0_y     <= '0;
                m_quad1_x     <= '0;
                m_quad1_y     <= '0;
                m_quad2_x     <= '0;
                m_quad2_y     <= '0;
                m_quad3_x     <= '0;
                m_quad3_y     <= '0;
                m_point_valid <= 1'b0;
                m_last_step   <= 1'b0;
            end else begin
                m_quad0_x     <= cx_w + x_w;
                m_quad0_y     <= cy_w + y_w;
                m_quad1_x     <= cx_w - x_w;
                m_quad1_y     <= cy_w + y_w;
                m_quad2_x     <= cx_w - x_w;
                m_quad2_y     <= cy_w - y_w;
                m_quad3_x     <= cx_w + x_w;
                m_quad3_y     <= cy_w - y_w;
                m_point_valid <= 1'b1;
                m_last_step   <= (y_reg == '0);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_step1_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_op == mer_pkg::ACC_STEP1) |-> (t_reg < u_reg && !region_two_reg))
        else $error("region one step outside region one");

    a_region_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_op == mer_pkg::ACC_R2_SUB && !cmd.load) |=> region_two_reg)
        else $error("region two not entered");

    a_y_nonzero_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_op == mer_pkg::ACC_STEP1 || cmd.acc_op == mer_pkg::ACC_STEP2)
        |-> (y_reg != '0))
        else $error("step taken after last row");
`endif

endmodule

FILE: rtl/midpoint_ellipse_rasterizer.sv
// Sequence: a start runs SQ_A, SQ_B, MUL_AB, INIT and EMIT; an advance runs STEP and
//   EMIT (R2_XX to R2_STEP between at a region change), or BLANK past the last step.
// Throughput: the next transaction is taken in the cycle the result register loads,
//   not before, bounded by the shared multiplier sequence and decision update.
// Reset: synchronous active low aresetn; clears the sequencer, result valid and the
//   step position, so an advance right after reset returns point_valid 0.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Integer midpoint ellipse stepper emitting four mirrored pixels per step.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_operation,
    input  logic        [mer_pkg::AXIS_BITS-1:0]    s_semi_axis_x,
    input  logic        [mer_pkg::AXIS_BITS-1:0]    s_semi_axis_y,
    input  logic signed [mer_pkg::CENTRE_BITS-1:0]  s_center_x,
    input  logic signed [mer_pkg::CENTRE_BITS-1:0]  s_center_y,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad0_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad0_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad1_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad1_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad2_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad2_y,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad3_x,
    output logic signed [mer_pkg::COORD_BITS-1:0]   m_quad3_y,
    output logic                                    m_point_valid,
    output logic                                    m_last_step
);

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;

    mer_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    mer_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_semi_axis_x (s_semi_axis_x),
        .s_semi_axis_y (s_semi_axis_y),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .m_quad0_x     (m_quad0_x),
        .m_quad0_y     (m_quad0_y),
        .m_quad1_x     (m_quad1_x),
        .m_quad1_y     (m_quad1_y),
        .m_quad2_x     (m_quad2_x),
        .m_quad2_y     (m_quad2_y),
        .m_quad3_x     (m_quad3_x),
        .m_quad3_y     (m_quad3_y),
        .m_point_valid (m_point_valid),
        .m_last_step   (m_last_step)
    );

endmodule

FILE: sim/tb_midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer
// Self-checking bench for the midpoint ellipse rasterizer. A scoreboard holds
// its own integer midpoint ellipse stepper: every accepted start or advance
// produces the four expected mirrored pixels with their flags, or a blank set
// with no ellipse in progress, and every result transaction is compared field
// by field with the oldest one pending. Stimulus begins with directed ellipses
// (degenerate axes, extreme centres, advances with no ellipse in progress),
// then random runs that are mostly whole ellipses with some abandoned runs,
// large axes and noise. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;

    typedef struct packed {
        logic signed [mer_pkg::COORD_BITS-1:0] q0x;
        logic signed [mer_pkg::COORD_BITS-1:0] q0y;
        logic signed [mer_pkg::COORD_BITS-1:0] q1x;
        logic signed [mer_pkg::COORD_BITS-1:0] q1y;
        logic signed [mer_pkg::COORD_BITS-1:0] q2x;
        logic signed [mer_pkg::COORD_BITS-1:0] q2y;
        logic signed [mer_pkg::COORD_BITS-1:0] q3x;
        logic signed [mer_pkg::COORD_BITS-1:0] q3y;
        logic                                  pv;
        logic                                  last;
    } pixel_set_t;

    class ellipse_scoreboard;
        logic        [mer_pkg::AXIS_BITS-1:0]   axis_a;
        logic        [mer_pkg::AXIS_BITS-1:0]   axis_b;
        logic signed [mer_pkg::CENTRE_BITS-1:0] org_x;
        logic signed [mer_pkg::CENTRE_BITS-1:0] org_y;
        longint     px;
        longint     py;
        longint     dec;
        bit         region_two;
        bit         run_over;
        pixel_set_t pixels_due[$];
        int         errors;
        int         checked;
        int         ellipses_done;

        function new();
            axis_a = '0;
            axis_b = '0;
            org_x = '0;
            org_y = '0;
            px = 0;
            py = 0;
            dec = 0;
            region_two = 0;
            run_over = 1;
            errors = 0;
            checked = 0;
            ellipses_done = 0;
        endfunction

        function pixel_set_t mirror_pixels();
            pixel_set_t p;
            longint cx;
            longint cy;
            cx = longint'(org_x);
            cy = longint'(org_y);
            p.q0x = mer_pkg::COORD_BITS'(cx + px);
            p.q0y = mer_pkg::COORD_BITS'(cy + py);
            p.q1x = mer_pkg::COORD_BITS'(cx - px);
            p.q1y = mer_pkg::COORD_BITS'(cy + py);
            p.q2x = mer_pkg::COORD_BITS'(cx - px);
            p.q2y = mer_pkg::COORD_BITS'(cy - py);
            p.q3x = mer_pkg::COORD_BITS'(cx + px);
            p.q3y = mer_pkg::COORD_BITS'(cy - py);
            p.pv = 1'b1;
            p.last = (py == 0);
            if (py == 0) begin
                run_over = 1;
                ellipses_done++;
            end
            return p;
        endfunction

        function void note_input(logic op,
                                 logic [mer_pkg::AXIS_BITS-1:0] a,
                                 logic [mer_pkg::AXIS_BITS-1:0] b,
                                 logic signed [mer_pkg::CENTRE_BITS-1:0] cx,
                                 logic signed [mer_pkg::CENTRE_BITS-1:0] cy);
            longint     a2;
            longint     b2;
            bit         moved;
            pixel_set_t blank;
            moved = 0;
            blank = '0;
            if (op == mer_pkg::OP_START) begin
                axis_a = a;
                axis_b = b;
                org_x = cx;
                org_y = cy;
                a2 = longint'(axis_a) * longint'(axis_a);
                b2 = longint'(axis_b) * longint'(axis_b);
                px = 0;
                py = longint'(axis_b);
                dec = 4 * (b2 - a2 * py) + a2;
                region_two = 0;
                run_over = 0;
                pixels_due.push_back(mirror_pixels());
                return;
            end
            if (run_over) begin
                pixels_due.push_back(blank);
                return;
            end
            a2 = longint'(axis_a) * longint'(axis_a);
            b2 = longint'(axis_b) * longint'(axis_b);
            if (!region_two) begin
                if (2 * b2 * (px + 1) < a2 * (2 * py - 1)) begin
                    if (dec < 0) begin
                        dec += 4 * b2 * (2 * px + 3);
                    end else begin
                        dec += 4 * b2 * (2 * px + 3) + 4 * a2 * (2 - 2 * py);
                        py--;
                    end
                    px++;
                    moved = 1;
                end else begin
                    // region two restarts from its own midpoint value
                    region_two = 1;
                    dec = 4 * b2 * (px * px + px) + b2
                        + 4 * a2 * (py - 1) * (py - 1) - 4 * a2 * b2;
                end
            end
            if (!moved) begin
                if (dec < 0) begin
                    dec += 4 * b2 * (2 * px + 2) + 4 * a2 * (3 - 2 * py);
                    px++;
                end else begin
                    dec += 4 * a2 * (3 - 2 * py);
                end
                py--;
            end
            pixels_due.push_back(mirror_pixels());
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(pixel_set_t got);
            pixel_set_t exp_p;
            if (pixels_due.size() == 0) begin
                $error("result transaction with nothing pending");
                errors++;
                return;
            end
            exp_p = pixels_due.pop_front();
            checked++;
            check_field("quad0_x", int'(exp_p.q0x), int'(got.q0x));
            check_field("quad0_y", int'(exp_p.q0y), int'(got.q0y));
            check_field("quad1_x", int'(exp_p.q1x), int'(got.q1x));
            check_field("quad1_y", int'(exp_p.q1y), int'(got.q1y));
            check_field("quad2_x", int'(exp_p.q2x), int'(got.q2x));
            check_field("quad2_y", int'(exp_p.q2y), int'(got.q2y));
            check_field("quad3_x", int'(exp_p.q3x), int'(got.q3x));
            check_field("quad3_y", int'(exp_p.q3y), int'(got.q3y));
            check_field("point_valid", int'(exp_p.pv), int'(got.pv));
            check_field("last_step", int'(exp_p.last), int'(got.last));
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    localparam int ITEM_TARGET = 1600;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_valid;
    logic                                   s_ready;
    logic                                   s_operation;
    logic        [mer_pkg::AXIS_BITS-1:0]   s_semi_axis_x;
    logic        [mer_pkg::AXIS_BITS-1:0]   s_semi_axis_y;
    logic signed [mer_pkg::CENTRE_BITS-1:0] s_center_x;
    logic signed [mer_pkg::CENTRE_BITS-1:0] s_center_y;
    logic                                   m_valid;
    logic                                   m_ready;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad0_x;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad0_y;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad1_x;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad1_y;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad2_x;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad2_y;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad3_x;
    logic signed [mer_pkg::COORD_BITS-1:0]  m_quad3_y;
    logic                                   m_point_valid;
    logic                                   m_last_step;

    ellipse_scoreboard sb = new();
    int tx_count = 0;
    int starts_sent = 0;
    bit tx_burst = 0;
    bit rx_burst = 0;

    midpoint_ellipse_rasterizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_semi_axis_x (s_semi_axis_x),
        .s_semi_axis_y (s_semi_axis_y),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quad0_x     (m_quad0_x),
        .m_quad0_y     (m_quad0_y),
        .m_quad1_x     (m_quad1_x),
        .m_quad1_y     (m_quad1_y),
        .m_quad2_x     (m_quad2_x),
        .m_quad2_y     (m_quad2_y),
        .m_quad3_x     (m_quad3_x),
        .m_quad3_y     (m_quad3_y),
        .m_point_valid (m_point_valid),
        .m_last_step   (m_last_step)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(logic op,
                             logic [mer_pkg::AXIS_BITS-1:0] a,
                             logic [mer_pkg::AXIS_BITS-1:0] b,
                             logic signed [mer_pkg::CENTRE_BITS-1:0] cx,
                             logic signed [mer_pkg::CENTRE_BITS-1:0] cy);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_semi_axis_x <= a;
        s_semi_axis_y <= b;
        s_center_x    <= cx;
        s_center_y    <= cy;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, a, b, cx, cy);
        tx_count++;
        if (op == mer_pkg::OP_START) starts_sent++;
    endtask

    task automatic send_advance();
        send_item(mer_pkg::OP_ADVANCE, mer_pkg::AXIS_BITS'($urandom),
                  mer_pkg::AXIS_BITS'($urandom),
                  mer_pkg::CENTRE_BITS'($urandom), mer_pkg::CENTRE_BITS'($urandom));
    endtask

    task automatic run_ellipse(logic [mer_pkg::AXIS_BITS-1:0] a,
                               logic [mer_pkg::AXIS_BITS-1:0] b,
                               logic signed [mer_pkg::CENTRE_BITS-1:0] cx,
                               logic signed [mer_pkg::CENTRE_BITS-1:0] cy, int max_adv);
        int n;
        n = 0;
        send_item(mer_pkg::OP_START, a, b, cx, cy);
        while (!sb.run_over && n < max_adv) begin
            send_advance();
            n++;
        end
    endtask

    function automatic logic [mer_pkg::AXIS_BITS-1:0] small_axis();
        if ($urandom_range(0, 31) == 0) return '0;
        return mer_pkg::AXIS_BITS'($urandom_range(1, 31));
    endfunction

    // result side
    initial begin
        pixel_set_t got;
        int         stall;
        int         rx_count;
        rx_count = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_count == HOLD_AT) stall = HOLD_CYCLES;
            else stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.q0x  = m_quad0_x;
            got.q0y  = m_quad0_y;
            got.q1x  = m_quad1_x;
            got.q1y  = m_quad1_y;
            got.q2x  = m_quad2_x;
            got.q2y  = m_quad2_y;
            got.q3x  = m_quad3_x;
            got.q3y  = m_quad3_y;
            got.pv   = m_point_valid;
            got.last = m_last_step;
            sb.check_result(got);
            rx_count++;
            if (rx_count % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int waited;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= mer_pkg::OP_ADVANCE;
        s_semi_axis_x <= '0;
        s_semi_axis_y <= '0;
        s_center_x    <= '0;
        s_center_y    <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing in progress after reset
        send_advance();
        // zero vertical axis: start point is the last step
        run_ellipse(0, 0, 0, 0, 0);
        send_advance();
        // zero horizontal axis at the centre extremes
        run_ellipse(0, 3, 511, -512, 10);
        send_advance();
        // largest axes at the centre extremes, abandoned by the next start
        run_ellipse(511, 511, -512, 511, 2);
        run_ellipse(1, 1, 0, 0, 10);
        run_ellipse(5, 2, -1, 1, 20);
        send_advance();

        while (tx_count < ITEM_TARGET) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 15))
                0: send_item(1'($urandom), mer_pkg::AXIS_BITS'($urandom),
                             mer_pkg::AXIS_BITS'($urandom),
                             mer_pkg::CENTRE_BITS'($urandom),
                             mer_pkg::CENTRE_BITS'($urandom));
                1: run_ellipse(small_axis(), small_axis(), mer_pkg::CENTRE_BITS'($urandom),
                               mer_pkg::CENTRE_BITS'($urandom), $urandom_range(0, 5));
                2: run_ellipse(mer_pkg::AXIS_BITS'($urandom), mer_pkg::AXIS_BITS'($urandom),
                               mer_pkg::CENTRE_BITS'($urandom),
                               mer_pkg::CENTRE_BITS'($urandom),
                               $urandom_range(1, 40));
                default: begin
                    run_ellipse(small_axis(), small_axis(),
                                mer_pkg::CENTRE_BITS'($urandom),
                                mer_pkg::CENTRE_BITS'($urandom), 10000);
                    if ($urandom_range(0, 3) == 0) send_advance();
                end
            endcase
        end
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (sb.pending() > 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("sent %0d transactions (%0d starts), %0d ellipses drawn to the end",
                 tx_count, starts_sent, sb.ellipses_done);
        $display("checked %0d result transactions, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
